[hw/rtl/wpd_pkg.sv]
package wpd_pkg;

  // register map: index taken from paddr[2]
  localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

  // report kinds
  localparam logic KIND_LOCAL   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // matrix_size register width and smallest usable size
  localparam int          SIZE_W   = 8;
  localparam logic [31:0] SIZE_MIN = 32'd3;

  // control bits carried with each result item
  typedef struct packed {
    logic kind;
    logic found;
    logic last;
  } rpt_flags_t;

endpackage

[hw/rtl/wpd_ram.sv]
module wpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/wpd_window.sv]
module wpd_window #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          shift,
  input  logic signed [VALUE_WIDTH-1:0] top,
  input  logic signed [VALUE_WIDTH-1:0] mid,
  input  logic signed [VALUE_WIDTH-1:0] sample,
  output logic signed [VALUE_WIDTH-1:0] center,
  output logic                          is_peak
);

  logic signed [VALUE_WIDTH-1:0] win [9];
  logic signed [VALUE_WIDTH-1:0] nb [8];
  logic [7:0]                    gt;

  // window slides one column left, new column enters on the right
  always_ff @(posedge clk) begin
    if (shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= top;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= mid;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= sample;
    end
  end

  // neighbors of the center as they stand after this shift
  always_comb begin
    nb[0] = win[1];
    nb[1] = win[2];
    nb[2] = top;
    nb[3] = win[4];
    nb[4] = mid;
    nb[5] = win[7];
    nb[6] = win[8];
    nb[7] = sample;
  end

  assign center = win[5];

  // eight parallel strict compares
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      gt[k] = center > nb[k];
    end
  end

  assign is_peak = &gt;

endmodule

[hw/rtl/wpd_result.sv]
module wpd_result
  import wpd_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  output logic                   load_ok,
  input  logic                   load,
  input  logic                   r0_valid,
  input  logic [VALUE_WIDTH-1:0] r0_value,
  input  logic [IDX_W-1:0]       r0_row,
  input  logic [IDX_W-1:0]       r0_col,
  input  rpt_flags_t             r0_flags,
  input  logic                   r1_valid,
  input  logic [VALUE_WIDTH-1:0] r1_value,
  input  logic [IDX_W-1:0]       r1_row,
  input  logic [IDX_W-1:0]       r1_col,
  input  rpt_flags_t             r1_flags,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic [IDX_W-1:0]       out_row,
  output logic [IDX_W-1:0]       out_col,
  output rpt_flags_t             out_flags
);

  logic                   v0;
  logic                   v1;
  logic [VALUE_WIDTH-1:0] value0;
  logic [VALUE_WIDTH-1:0] value1;
  logic [IDX_W-1:0]       row0;
  logic [IDX_W-1:0]       row1;
  logic [IDX_W-1:0]       col0;
  logic [IDX_W-1:0]       col1;
  rpt_flags_t             flags0;
  rpt_flags_t             flags1;
  logic                   pop;

  assign out_valid = v0 | v1;
  assign pop       = out_valid & out_ready;

  // a new pair may enter once whatever is held goes out this cycle
  assign load_ok = (!v0 && !v1) || (pop && (v0 ^ v1));

  // slot 0 goes out first
  assign out_value = v0 ? value0 : value1;
  assign out_row   = v0 ? row0   : row1;
  assign out_col   = v0 ? col0   : col1;
  assign out_flags = v0 ? flags0 : flags1;

  // pair of result slots
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (load) begin
      v0 <= r0_valid;
      v1 <= r1_valid;
    end else if (pop) begin
      if (v0) begin
        v0 <= 1'b0;
      end else begin
        v1 <= 1'b0;
      end
    end
    if (load) begin
      value0 <= r0_value;
      row0   <= r0_row;
      col0   <= r0_col;
      flags0 <= r0_flags;
      value1 <= r1_value;
      row1   <= r1_row;
      col1   <= r1_col;
      flags1 <= r1_flags;
    end
  end

endmodule

[hw/rtl/window_peak_detector_3x3_core.sv]
// an accepted item goes from s1 into the result slots, where its first result shows
// throughput: one item per cycle while no result waits on report_ready; the item at
//   the last cell with a local peak fills both slots, and the next item waits for them
// line stores are one dual-port RAM each, read when an item is accepted
// reset: synchronous, clears counters, best peak and result slots; size reads 128
module window_peak_detector_3x3_core
  import wpd_pkg::*;
#(
  parameter int MAX_SIZE    = 128,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [2:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic signed [VALUE_WIDTH-1:0]          sample,
  output logic                                   report_valid,
  input  logic                                   report_ready,
  output logic                                   report_kind,
  output logic signed [VALUE_WIDTH-1:0]          peak_value,
  output logic [$clog2(MAX_SIZE)-1:0]            peak_row,
  output logic [$clog2(MAX_SIZE)-1:0]            peak_col,
  output logic                                   peak_found,
  output logic                                   last_of_run
);

  localparam int IDX_W      = $clog2(MAX_SIZE);
  localparam int RESET_SIZE = (MAX_SIZE < 128) ? MAX_SIZE : 128;

  logic [SIZE_W-1:0]      matrix_size;
  logic [IDX_W-1:0]       last_idx;
  logic [IDX_W-1:0]       last_idx_next;
  logic [31:0]            size_ext;
  logic [31:0]            size_m1;
  logic                   cfg_write;

  logic [IDX_W-1:0]       row_count;
  logic [IDX_W-1:0]       col_count;
  logic                   accept;

  logic                   s1_valid;
  logic signed [VALUE_WIDTH-1:0] s1_sample;
  logic [IDX_W-1:0]       s1_addr;
  logic [IDX_W-1:0]       s1_row;
  logic [IDX_W-1:0]       s1_col;
  logic                   s1_test;
  logic                   s1_summary;
  logic                   s1_adv;

  logic signed [VALUE_WIDTH-1:0] top;
  logic signed [VALUE_WIDTH-1:0] mid;
  logic signed [VALUE_WIDTH-1:0] center;
  logic                   is_peak;

  logic signed [VALUE_WIDTH-1:0] best_value;
  logic [IDX_W-1:0]       best_row;
  logic [IDX_W-1:0]       best_col;
  logic                   best_valid;
  logic signed [VALUE_WIDTH-1:0] best_value_next;
  logic [IDX_W-1:0]       best_row_next;
  logic [IDX_W-1:0]       best_col_next;
  logic                   best_valid_next;
  logic                   peak_hit;
  logic                   best_take;

  logic                   load_ok;
  logic                   r0_valid;
  logic [VALUE_WIDTH-1:0] r0_value;
  logic [IDX_W-1:0]       r0_row;
  logic [IDX_W-1:0]       r0_col;
  rpt_flags_t             r0_flags;
  logic                   r1_valid;
  logic [VALUE_WIDTH-1:0] r1_value;
  logic [IDX_W-1:0]       r1_row;
  logic [IDX_W-1:0]       r1_col;
  rpt_flags_t             r1_flags;
  logic [VALUE_WIDTH-1:0] sum_value;
  logic [IDX_W-1:0]       sum_row;
  logic [IDX_W-1:0]       sum_col;
  logic [VALUE_WIDTH-1:0] out_value;
  rpt_flags_t             out_flags;

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[2:2] == REG_MATRIX_SIZE);
  assign prdata    = (paddr[2:2] == REG_MATRIX_SIZE) ?
                     {{(32 - SIZE_W){1'b0}}, matrix_size} : 32'd0;

  // clamp the written size into 3..MAX_SIZE, keep size-1 as last index
  assign size_ext = {{(32 - SIZE_W){1'b0}}, pwdata[SIZE_W-1:0]};
  always_comb begin
    if (size_ext < SIZE_MIN) begin
      size_m1 = SIZE_MIN - 32'd1;
    end else if (size_ext > 32'(MAX_SIZE)) begin
      size_m1 = 32'(MAX_SIZE) - 32'd1;
    end else begin
      size_m1 = size_ext - 32'd1;
    end
    last_idx_next = size_m1[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_W'(128);
      last_idx    <= IDX_W'(RESET_SIZE - 1);
    end else if (cfg_write) begin
      matrix_size <= pwdata[SIZE_W-1:0];
      last_idx    <= last_idx_next;
    end
  end

  // input side: s1 frees up when its item moves on
  assign sample_ready = !s1_valid || s1_adv;
  assign accept       = sample_valid & sample_ready;
  assign s1_adv       = s1_valid & load_ok;

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_count == last_idx) begin
        col_count <= '0;
        row_count <= (row_count == last_idx) ? '0 : row_count + IDX_W'(1);
      end else begin
        col_count <= col_count + IDX_W'(1);
      end
    end
  end

  // input register, line store read issued in the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_sample  <= sample;
      s1_addr    <= col_count;
      s1_row     <= row_count - IDX_W'(1);
      s1_col     <= col_count - IDX_W'(1);
      s1_test    <= (row_count >= IDX_W'(2)) && (col_count >= IDX_W'(2));
      s1_summary <= (row_count == last_idx) && (col_count == last_idx);
    end
  end

  // line store a: previous row, line store b: row before that
  wpd_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_SIZE)
  ) u_line_a (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata (s1_sample),
    .re    (accept),
    .raddr (col_count),
    .rdata (mid)
  );

  wpd_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_SIZE)
  ) u_line_b (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata (mid),
    .re    (accept),
    .raddr (col_count),
    .rdata (top)
  );

  wpd_window #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_window (
    .clk     (clk),
    .shift   (s1_adv),
    .top     (top),
    .mid     (mid),
    .sample  (s1_sample),
    .center  (center),
    .is_peak (is_peak)
  );

  // running best over local peaks, first one wins on ties
  assign peak_hit  = s1_test & is_peak;
  assign best_take = peak_hit && (!best_valid || (center > best_value));

  always_comb begin
    best_value_next = best_value;
    best_row_next   = best_row;
    best_col_next   = best_col;
    best_valid_next = best_valid;
    if (best_take) begin
      best_value_next = center;
      best_row_next   = s1_row;
      best_col_next   = s1_col;
      best_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      best_value <= '0;
      best_row   <= '0;
      best_col   <= '0;
      best_valid <= 1'b0;
    end else if (s1_adv) begin
      if (s1_summary) begin
        best_value <= '0;
        best_row   <= '0;
        best_col   <= '0;
        best_valid <= 1'b0;
      end else begin
        best_value <= best_value_next;
        best_row   <= best_row_next;
        best_col   <= best_col_next;
        best_valid <= best_valid_next;
      end
    end
  end

  // summary fields, zero when no peak was found
  assign sum_value = best_valid_next ? best_value_next : '0;
  assign sum_row   = best_valid_next ? best_row_next   : '0;
  assign sum_col   = best_valid_next ? best_col_next   : '0;

  // result pair: local report first, summary after it
  always_comb begin
    r1_valid = peak_hit & s1_summary;
    r1_value = sum_value;
    r1_row   = sum_row;
    r1_col   = sum_col;
    r1_flags = '{kind: KIND_SUMMARY, found: best_valid_next, last: 1'b1};
    r0_valid = peak_hit | s1_summary;
    if (peak_hit) begin
      r0_value = center;
      r0_row   = s1_row;
      r0_col   = s1_col;
      r0_flags = '{kind: KIND_LOCAL, found: 1'b0, last: !s1_summary};
    end else begin
      r0_value = sum_value;
      r0_row   = sum_row;
      r0_col   = sum_col;
      r0_flags = '{kind: KIND_SUMMARY, found: best_valid_next, last: 1'b1};
    end
  end

  wpd_result #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W)
  ) u_result (
    .clk       (clk),
    .rst       (rst),
    .load_ok   (load_ok),
    .load      (s1_adv),
    .r0_valid  (r0_valid),
    .r0_value  (r0_value),
    .r0_row    (r0_row),
    .r0_col    (r0_col),
    .r0_flags  (r0_flags),
    .r1_valid  (r1_valid),
    .r1_value  (r1_value),
    .r1_row    (r1_row),
    .r1_col    (r1_col),
    .r1_flags  (r1_flags),
    .out_valid (report_valid),
    .out_ready (report_ready),
    .out_value (out_value),
    .out_row   (peak_row),
    .out_col   (peak_col),
    .out_flags (out_flags)
  );

  assign peak_value  = out_value;
  assign report_kind = out_flags.kind;
  assign peak_found  = out_flags.found;
  assign last_of_run = out_flags.last;

endmodule

[hw/rtl/wpd_checker.sv]
module wpd_checker
  import wpd_pkg::*;
#(
  parameter int MAX_SIZE    = 128,
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          report_valid,
  input logic                          report_ready,
  input logic                          report_kind,
  input logic signed [VALUE_WIDTH-1:0] peak_value,
  input logic [$clog2(MAX_SIZE)-1:0]   peak_row,
  input logic [$clog2(MAX_SIZE)-1:0]   peak_col,
  input logic                          peak_found,
  input logic                          last_of_run
);

  // a stalled result item stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid)
    else $error("result item dropped while stalled");

  // a summary always closes the run of its item
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    report_valid && (report_kind == KIND_SUMMARY) |-> last_of_run)
    else $error("summary without last_of_run");

  // local reports never carry the found flag
  a_local_found: assert property (@(posedge clk) disable iff (rst)
    report_valid && (report_kind == KIND_LOCAL) |-> !peak_found)
    else $error("local report with peak_found set");

  // an empty summary carries all-zero fields
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    report_valid && (report_kind == KIND_SUMMARY) && !peak_found |->
      (peak_value == '0) && (peak_row == '0) && (peak_col == '0))
    else $error("empty summary with nonzero fields");

endmodule

bind window_peak_detector_3x3_core wpd_checker #(
  .MAX_SIZE    (MAX_SIZE),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_checker (.*);
